>>> hdl/rswm_pkg.sv
`timescale 1ns / 1ps
// Package for the ring suffix word matcher: field widths, opcodes and
// default sizes. It has no dependencies.

package rswm_pkg;

  // Default sizes of the key ring and the word table.
  localparam int RING_DEPTH_DEF   = 32;
  localparam int MAX_WORDS_DEF    = 8;
  localparam int MAX_WORD_LEN_DEF = 16;

  // Fixed widths of the item and result fields.
  localparam int OPCODE_W = 2;
  localparam int CHAR_W   = 8;
  localparam int WIDX_W   = 3;
  localparam int CPOS_W   = 4;
  localparam int WLEN_W   = 5;
  localparam int NUM_W    = 3;
  localparam int CFG_W    = 4;

  // Opcodes of an input item.
  localparam logic [OPCODE_W-1:0] OP_PUSH  = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_WCHAR = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_WLEN  = 2'd2;
  localparam logic [OPCODE_W-1:0] OP_SCAN  = 2'd3;

endpackage

>>> hdl/ring_suffix_word_matcher_unit.sv
`timescale 1ns / 1ps
// Top level of the ring suffix word matcher: key ring, word table and the
// scan sequencer with its single byte comparator. Depends on rswm_pkg.

// Push, word character and word length items finish in the cycle they are
// accepted and produce no result; busy_o stays low. A scan item raises
// busy_o and walks the words in use in table order, comparing one word byte
// against one ring byte per cycle on a single comparator, newest key first.
// A word takes a setup step, the reads of its bytes and the compare of its
// last byte, an empty word the setup step only; the end-of-table check and
// the final result close the scan.
// A mismatch ends a word early. Results come out on
// res_strobe_o for one cycle each and cannot be held off; every matching
// word gives one result, a scan without a match gives one result with
// fired_o low, and the final result of a scan has last_o high. busy_o falls
// in the cycle that carries the final result. Word bytes that were never
// written read as unknown values. The configuration channel is always ready
// and must only be written while busy_o is low.

module ring_suffix_word_matcher_unit #(
  parameter int RING_DEPTH   = rswm_pkg::RING_DEPTH_DEF,
  parameter int MAX_WORDS    = rswm_pkg::MAX_WORDS_DEF,
  parameter int MAX_WORD_LEN = rswm_pkg::MAX_WORD_LEN_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Command channel
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic [rswm_pkg::OPCODE_W-1:0] opcode_i,
  input  logic [rswm_pkg::CHAR_W-1:0]   key_char_i,
  input  logic [rswm_pkg::WIDX_W-1:0]   word_index_i,
  input  logic [rswm_pkg::CPOS_W-1:0]   char_position_i,
  input  logic [rswm_pkg::CHAR_W-1:0]   word_char_i,
  input  logic [rswm_pkg::WLEN_W-1:0]   word_length_i,
  // Result channel
  output logic                         res_strobe_o,
  output logic                         fired_o,
  output logic [rswm_pkg::NUM_W-1:0]    word_number_o,
  output logic                         last_o,
  // Configuration channel
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [rswm_pkg::CFG_W-1:0]    cfg_data_i
);

  localparam int RA_W  = (RING_DEPTH > 2) ? $clog2(RING_DEPTH) : 1;
  localparam int WI_W  = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int WQ_W  = $clog2(MAX_WORDS + 1);
  localparam int LEN_W = $clog2(MAX_WORD_LEN + 1);
  localparam int CHARS = MAX_WORDS * MAX_WORD_LEN;
  localparam int CA_W  = (CHARS > 1) ? $clog2(CHARS) : 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WORD = 2'd1;
  localparam logic [1:0] ST_RUN  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]                   state_q, state_d;
  logic [WQ_W-1:0]              word_q, word_d;
  logic [LEN_W-1:0]             pos_q, pos_d;
  logic [RA_W-1:0]              rptr_q, rptr_d;
  logic                         iss_q, iss_d;
  logic                         cmp_vld_q, cmp_vld_d;
  logic                         cmp_last_q, cmp_last_d;
  logic                         pend_vld_q, pend_vld_d;
  logic [rswm_pkg::NUM_W-1:0]   pend_num_q, pend_num_d;
  logic                         res_strobe_q, res_strobe_d;
  logic                         fired_q, fired_d;
  logic [rswm_pkg::NUM_W-1:0]   num_q, num_d;
  logic                         last_q, last_d;
  logic [rswm_pkg::CFG_W-1:0]   words_in_use_q;
  logic [RA_W-1:0]              wp_q;

  logic [rswm_pkg::CHAR_W-1:0]  ring_mem [RING_DEPTH];
  logic [RING_DEPTH-1:0]        ring_vld_q;
  logic [rswm_pkg::CHAR_W-1:0]  ring_rd_q;
  logic                         ring_rdv_q;
  logic [rswm_pkg::CHAR_W-1:0]  char_mem [CHARS];
  logic [rswm_pkg::CHAR_W-1:0]  char_rd_q;
  logic [LEN_W-1:0]             len_q [MAX_WORDS];

  logic                         accept;
  logic                         push_en, wchar_en, wlen_en;
  logic [WI_W-1:0]              widx;
  logic [CA_W-1:0]              wr_addr, rd_addr;
  logic [LEN_W-1:0]             wlen_clamped;
  logic [LEN_W-1:0]             cur_len;
  logic [7:0]                   words_limit;
  logic [rswm_pkg::CHAR_W-1:0]  key_byte;
  logic                         mismatch;
  logic                         match_evt;

  // Item handshake and decode of the table and ring writes.
  assign accept   = start_i && !busy_o;
  assign push_en  = accept && (opcode_i == rswm_pkg::OP_PUSH);
  assign wchar_en = accept && (opcode_i == rswm_pkg::OP_WCHAR)
                    && (7'(word_index_i) < 7'(MAX_WORDS))
                    && (6'(char_position_i) < 6'(MAX_WORD_LEN));
  assign wlen_en  = accept && (opcode_i == rswm_pkg::OP_WLEN)
                    && (7'(word_index_i) < 7'(MAX_WORDS));
  assign widx     = WI_W'(word_index_i);
  assign wr_addr  = CA_W'(32'(widx) * 32'(MAX_WORD_LEN) + 32'(char_position_i));
  assign rd_addr  = CA_W'(32'(word_q) * 32'(MAX_WORD_LEN) + 32'(pos_q));
  assign wlen_clamped = (6'(word_length_i) > 6'(MAX_WORD_LEN)) ?
                        LEN_W'(MAX_WORD_LEN) : LEN_W'(word_length_i);

  // Scan limits and the byte comparator.
  assign cur_len     = len_q[word_q[WI_W-1:0]];
  assign words_limit = (8'(words_in_use_q) > 8'(MAX_WORDS)) ?
                       8'(MAX_WORDS) : 8'(words_in_use_q);
  assign key_byte    = ring_rdv_q ? ring_rd_q : '0;
  assign mismatch    = (char_rd_q != key_byte);

  // Configuration register.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      words_in_use_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      words_in_use_q <= cfg_data_i;
    end
  end

  // Write position and per-entry valid bits of the key ring.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q       <= '0;
      ring_vld_q <= '0;
    end else if (push_en) begin
      ring_vld_q[wp_q] <= 1'b1;
      wp_q <= (wp_q == RA_W'(RING_DEPTH - 1)) ? '0 : wp_q + 1'b1;
    end
  end

  // Key ring memory with a registered read port.
  always_ff @(posedge clk_i) begin
    if (push_en) begin
      ring_mem[wp_q] <= key_char_i;
    end
    ring_rd_q <= ring_mem[rptr_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_rdv_q <= 1'b0;
    end else begin
      ring_rdv_q <= ring_vld_q[rptr_q];
    end
  end

  // Word character memory with a registered read port.
  always_ff @(posedge clk_i) begin
    if (wchar_en) begin
      char_mem[wr_addr] <= word_char_i;
    end
    char_rd_q <= char_mem[rd_addr];
  end

  // Word lengths, cleared by reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_WORDS; i++) begin
        len_q[i] <= '0;
      end
    end else if (wlen_en) begin
      len_q[widx] <= wlen_clamped;
    end
  end

  // Scan sequencer. Each word is read from its last byte backward while the
  // ring pointer walks back from the newest key; reads and compares overlap.
  always_comb begin
    state_d      = state_q;
    word_d       = word_q;
    pos_d        = pos_q;
    rptr_d       = rptr_q;
    iss_d        = iss_q;
    cmp_vld_d    = cmp_vld_q;
    cmp_last_d   = cmp_last_q;
    pend_vld_d   = pend_vld_q;
    pend_num_d   = pend_num_q;
    res_strobe_d = 1'b0;
    fired_d      = fired_q;
    num_d        = num_q;
    last_d       = last_q;
    match_evt    = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept && (opcode_i == rswm_pkg::OP_SCAN)) begin
          state_d    = ST_WORD;
          word_d     = '0;
          pend_vld_d = 1'b0;
        end
      end
      ST_WORD: begin
        if (8'(word_q) >= words_limit) begin
          state_d = ST_DONE;
        end else if (cur_len == '0) begin
          match_evt = 1'b1;
          word_d    = word_q + 1'b1;
        end else begin
          pos_d     = cur_len - 1'b1;
          rptr_d    = (wp_q == '0) ? RA_W'(RING_DEPTH - 1) : wp_q - 1'b1;
          iss_d     = 1'b1;
          cmp_vld_d = 1'b0;
          state_d   = ST_RUN;
        end
      end
      ST_RUN: begin
        // Issue the read of the next byte pair.
        if (iss_q) begin
          cmp_vld_d  = 1'b1;
          cmp_last_d = (pos_q == '0);
          if (pos_q == '0) begin
            iss_d = 1'b0;
          end else begin
            pos_d = pos_q - 1'b1;
          end
          rptr_d = (rptr_q == '0) ? RA_W'(RING_DEPTH - 1) : rptr_q - 1'b1;
        end else begin
          cmp_vld_d = 1'b0;
        end
        // Compare the pair read in the previous cycle.
        if (cmp_vld_q && (mismatch || cmp_last_q)) begin
          match_evt = !mismatch;
          word_d    = word_q + 1'b1;
          state_d   = ST_WORD;
          iss_d     = 1'b0;
          cmp_vld_d = 1'b0;
        end
      end
      ST_DONE: begin
        res_strobe_d = 1'b1;
        fired_d      = pend_vld_q;
        num_d        = pend_vld_q ? pend_num_q : '0;
        last_d       = 1'b1;
        pend_vld_d   = 1'b0;
        state_d      = ST_IDLE;
      end
    endcase

    // A match is held back until the next one shows it is not the last.
    if (match_evt) begin
      if (pend_vld_q) begin
        res_strobe_d = 1'b1;
        fired_d      = 1'b1;
        num_d        = pend_num_q;
        last_d       = 1'b0;
      end
      pend_vld_d = 1'b1;
      pend_num_d = rswm_pkg::NUM_W'(word_q);
    end
  end

  // Sequencer control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      iss_q        <= 1'b0;
      cmp_vld_q    <= 1'b0;
      pend_vld_q   <= 1'b0;
      res_strobe_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      iss_q        <= iss_d;
      cmp_vld_q    <= cmp_vld_d;
      pend_vld_q   <= pend_vld_d;
      res_strobe_q <= res_strobe_d;
    end
  end

  // Sequencer payload registers.
  always_ff @(posedge clk_i) begin
    word_q     <= word_d;
    pos_q      <= pos_d;
    rptr_q     <= rptr_d;
    cmp_last_q <= cmp_last_d;
    pend_num_q <= pend_num_d;
    fired_q    <= fired_d;
    num_q      <= num_d;
    last_q     <= last_d;
  end

  // Outputs.
  assign busy_o        = (state_q != ST_IDLE);
  assign res_strobe_o  = res_strobe_q;
  assign fired_o       = fired_q;
  assign word_number_o = num_q;
  assign last_o        = last_q;

  // The final result of a scan appears once the block is free again.
  a_last_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o && last_o |-> !busy_o)
    else $error("final result while still busy");

  // An accepted scan keeps the block busy in the next cycle.
  a_scan_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (opcode_i == rswm_pkg::OP_SCAN) |=> busy_o)
    else $error("scan accepted but block not busy");

  // Table and ring writes produce no result.
  a_write_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (opcode_i != rswm_pkg::OP_SCAN) |=> !res_strobe_o)
    else $error("result after a non-scan item");

  // A no-match result is the only result of its scan.
  a_nomatch_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o && !fired_o |-> last_o && (word_number_o == '0))
    else $error("malformed no-match result");

  // Compares only happen while a word is being walked.
  a_cmp_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmp_vld_q |-> (state_q == ST_RUN))
    else $error("compare pending outside the word walk");

endmodule

>>> bench/ring_suffix_word_matcher_unit_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for ring_suffix_word_matcher_unit. A scoreboard class
// tracks the key ring and the word table and predicts every scan result.
// Depends on rswm_pkg and the unit under test.

module ring_suffix_word_matcher_unit_test;

  localparam int PHASE_ITEMS = 20;
  localparam int TAIL_CYCLES = 150;
  localparam int SETTLE_CYCLES = 4;

  // One command item, field by field at the port widths.
  typedef struct packed {
    logic [rswm_pkg::OPCODE_W-1:0] opcode;
    logic [rswm_pkg::CHAR_W-1:0]   key_char;
    logic [rswm_pkg::WIDX_W-1:0]   word_index;
    logic [rswm_pkg::CPOS_W-1:0]   char_position;
    logic [rswm_pkg::CHAR_W-1:0]   word_char;
    logic [rswm_pkg::WLEN_W-1:0]   word_length;
  } cmd_t;

  // One scan result.
  typedef struct packed {
    logic                       fired;
    logic [rswm_pkg::NUM_W-1:0] word_number;
    logic                       last;
  } hit_t;

  // Mirror of the key ring and word table; holds the results still to come.
  class word_match_tracker;
    logic [rswm_pkg::CHAR_W-1:0] key_ring [rswm_pkg::RING_DEPTH_DEF];
    int                          head;
    logic [rswm_pkg::CHAR_W-1:0] word_bytes [rswm_pkg::MAX_WORDS_DEF]
                                            [rswm_pkg::MAX_WORD_LEN_DEF];
    bit                          byte_set [rswm_pkg::MAX_WORDS_DEF]
                                          [rswm_pkg::MAX_WORD_LEN_DEF];
    int                          word_len [rswm_pkg::MAX_WORDS_DEF];
    int                          words_in_use;
    hit_t                        expected_hits [$];
    int                          mismatches;

    function new();
      foreach (key_ring[i]) key_ring[i] = '0;
      foreach (byte_set[w, p]) begin
        byte_set[w][p] = 1'b0;
        word_bytes[w][p] = '0;
      end
      foreach (word_len[w]) word_len[w] = 0;
      head = 0;
      words_in_use = 0;
      mismatches = 0;
    endfunction

    // A setting above the table size scans the whole table.
    function int scan_span();
      return (words_in_use > rswm_pkg::MAX_WORDS_DEF) ? rswm_pkg::MAX_WORDS_DEF
                                                      : words_in_use;
    endfunction

    // The word's last byte lines up with the newest key; empty words always hit.
    function bit word_hits(int w);
      int len;
      int base;
      len = word_len[w];
      base = (head + rswm_pkg::RING_DEPTH_DEF - (len % rswm_pkg::RING_DEPTH_DEF))
             % rswm_pkg::RING_DEPTH_DEF;
      for (int i = 0; i < len; i++)
        if (word_bytes[w][i] !== key_ring[(base + i) % rswm_pkg::RING_DEPTH_DEF])
          return 1'b0;
      return 1'b1;
    endfunction

    // One result per matching word, or a single no-match result.
    function void predict_scan();
      bit [rswm_pkg::MAX_WORDS_DEF-1:0] hit_mask;
      int final_hit;
      hit_t r;
      hit_mask = '0;
      final_hit = -1;
      for (int w = 0; w < scan_span(); w++) begin
        if (word_hits(w)) begin
          hit_mask[w] = 1'b1;
          final_hit = w;
        end
      end
      if (final_hit < 0) begin
        r.fired = 1'b0;
        r.word_number = '0;
        r.last = 1'b1;
        expected_hits.push_back(r);
      end else begin
        for (int w = 0; w <= final_hit; w++) begin
          if (hit_mask[w]) begin
            r.fired = 1'b1;
            r.word_number = rswm_pkg::NUM_W'(w);
            r.last = (w == final_hit);
            expected_hits.push_back(r);
          end
        end
      end
    endfunction

    // Update the mirror for an accepted item.
    function void note_item(cmd_t c);
      case (c.opcode)
        rswm_pkg::OP_PUSH: begin
          key_ring[head] = c.key_char;
          head = (head + 1) % rswm_pkg::RING_DEPTH_DEF;
        end
        rswm_pkg::OP_WCHAR: begin
          if (c.word_index < rswm_pkg::MAX_WORDS_DEF &&
              c.char_position < rswm_pkg::MAX_WORD_LEN_DEF) begin
            word_bytes[c.word_index][c.char_position] = c.word_char;
            byte_set[c.word_index][c.char_position] = 1'b1;
          end
        end
        rswm_pkg::OP_WLEN: begin
          if (c.word_index < rswm_pkg::MAX_WORDS_DEF)
            word_len[c.word_index] = (c.word_length > rswm_pkg::MAX_WORD_LEN_DEF) ?
                                     rswm_pkg::MAX_WORD_LEN_DEF : int'(c.word_length);
        end
        rswm_pkg::OP_SCAN: predict_scan();
        default: ;
      endcase
    endfunction

    // Finds a word byte that a scan would read but that was never written.
    function bit find_unset(output int w, output int p);
      for (int i = 0; i < scan_span(); i++) begin
        for (int j = 0; j < word_len[i]; j++) begin
          if (!byte_set[i][j]) begin
            w = i;
            p = j;
            return 1'b1;
          end
        end
      end
      w = 0;
      p = 0;
      return 1'b0;
    endfunction

    function void check_field(string name, int want, int got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        mismatches++;
      end
    endfunction

    // Compare one result with the oldest outstanding expectation.
    function void check_result(logic fired, logic [rswm_pkg::NUM_W-1:0] number,
                               logic last);
      hit_t want;
      if (expected_hits.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual fired=%0d word_number=%0d last=%0d",
                 $time, fired, number, last);
        mismatches++;
        return;
      end
      want = expected_hits.pop_front();
      check_field("fired", want.fired, fired);
      check_field("word_number", want.word_number, number);
      check_field("last", want.last, last);
    endfunction
  endclass

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          start_i = 1'b0;
  logic                          busy_o;
  logic [rswm_pkg::OPCODE_W-1:0] opcode_i = '0;
  logic [rswm_pkg::CHAR_W-1:0]   key_char_i = '0;
  logic [rswm_pkg::WIDX_W-1:0]   word_index_i = '0;
  logic [rswm_pkg::CPOS_W-1:0]   char_position_i = '0;
  logic [rswm_pkg::CHAR_W-1:0]   word_char_i = '0;
  logic [rswm_pkg::WLEN_W-1:0]   word_length_i = '0;
  logic                          res_strobe_o;
  logic                          fired_o;
  logic [rswm_pkg::NUM_W-1:0]    word_number_o;
  logic                          last_o;
  logic                          cfg_valid_i = 1'b0;
  logic                          cfg_ready_o;
  logic [rswm_pkg::CFG_W-1:0]    cfg_data_i = '0;

  word_match_tracker tracker;
  bit                idle_en = 1'b0;
  int                items_sent = 0;

  ring_suffix_word_matcher_unit uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .opcode_i        (opcode_i),
    .key_char_i      (key_char_i),
    .word_index_i    (word_index_i),
    .char_position_i (char_position_i),
    .word_char_i     (word_char_i),
    .word_length_i   (word_length_i),
    .res_strobe_o    (res_strobe_o),
    .fired_o         (fired_o),
    .word_number_o   (word_number_o),
    .last_o          (last_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  // Every strobed result is checked at the edge that ends its cycle.
  always @(posedge clk_i) begin
    if (rst_ni && res_strobe_o) tracker.check_result(fired_o, word_number_o, last_o);
  end

  // Unused fields carry random values so that they are exercised too.
  function automatic cmd_t random_cmd(logic [rswm_pkg::OPCODE_W-1:0] op);
    cmd_t c;
    c.opcode = op;
    c.key_char = rswm_pkg::CHAR_W'($urandom_range(0, 255));
    c.word_index = rswm_pkg::WIDX_W'($urandom_range(0, 7));
    c.char_position = rswm_pkg::CPOS_W'($urandom_range(0, 15));
    c.word_char = rswm_pkg::CHAR_W'($urandom_range(0, 255));
    c.word_length = rswm_pkg::WLEN_W'($urandom_range(0, 31));
    return c;
  endfunction

  // Mostly a small alphabet, so that typed keys often match a word.
  function automatic logic [rswm_pkg::CHAR_W-1:0] pick_char();
    case ($urandom_range(0, 4))
      0: return 8'h00;
      1: return 8'h61;
      2: return 8'h62;
      3: return 8'hff;
      default: return rswm_pkg::CHAR_W'($urandom_range(0, 255));
    endcase
  endfunction

  // Present one item, after a random gap if idle_en is set, and hold it until the unit takes it.
  task automatic send_item(input cmd_t c);
    int gap;
    gap = idle_en ? $urandom_range(0, 16) : 0;
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    opcode_i <= c.opcode;
    key_char_i <= c.key_char;
    word_index_i <= c.word_index;
    char_position_i <= c.char_position;
    word_char_i <= c.word_char;
    word_length_i <= c.word_length;
    do @(posedge clk_i); while (busy_o);
    tracker.note_item(c);
    items_sent++;
  endtask

  task automatic push_key(input logic [rswm_pkg::CHAR_W-1:0] k);
    cmd_t c;
    c = random_cmd(rswm_pkg::OP_PUSH);
    c.key_char = k;
    send_item(c);
  endtask

  task automatic write_char(input int w, input int p,
                            input logic [rswm_pkg::CHAR_W-1:0] ch);
    cmd_t c;
    c = random_cmd(rswm_pkg::OP_WCHAR);
    c.word_index = rswm_pkg::WIDX_W'(w);
    c.char_position = rswm_pkg::CPOS_W'(p);
    c.word_char = ch;
    send_item(c);
  endtask

  task automatic write_len(input int w, input int l);
    cmd_t c;
    c = random_cmd(rswm_pkg::OP_WLEN);
    c.word_index = rswm_pkg::WIDX_W'(w);
    c.word_length = rswm_pkg::WLEN_W'(l);
    send_item(c);
  endtask

  // A scan never reads a word byte that was not written: fill such bytes first.
  task automatic scan_words();
    int w;
    int p;
    while (tracker.find_unset(w, p)) write_char(w, p, pick_char());
    send_item(random_cmd(rswm_pkg::OP_SCAN));
  endtask

  // Load a whole word; lengths above the maximum are stored clamped.
  task automatic program_word(input int w, input int l);
    int stored;
    stored = (l > rswm_pkg::MAX_WORD_LEN_DEF) ? rswm_pkg::MAX_WORD_LEN_DEF : l;
    for (int i = 0; i < stored; i++) write_char(w, i, pick_char());
    write_len(w, l);
  endtask

  // Type a word after a few stray keys, sometimes with one wrong key, then scan.
  task automatic type_word(input int w);
    int len;
    int bad;
    logic [rswm_pkg::CHAR_W-1:0] k;
    len = tracker.word_len[w];
    bad = ($urandom_range(0, 3) == 0) ? $urandom_range(0, len) : -1;
    repeat ($urandom_range(0, 3)) push_key(pick_char());
    for (int i = 0; i < len; i++) begin
      k = tracker.byte_set[w][i] ? tracker.word_bytes[w][i] : pick_char();
      if (i == bad) k = ~k;
      push_key(k);
    end
    scan_words();
  endtask

  function automatic logic [rswm_pkg::OPCODE_W-1:0] OP_OPCODE_ANY();
    return rswm_pkg::OPCODE_W'($urandom_range(0, 3));
  endfunction

  task automatic noise_item();
    cmd_t c;
    c = random_cmd(OP_OPCODE_ANY());
    if (c.opcode == rswm_pkg::OP_SCAN) scan_words();
    else send_item(c);
  endtask

  // Hold off until every expected result has come and the unit is idle.
  task automatic wait_drained();
    start_i <= 1'b0;
    while (tracker.expected_hits.size() != 0 || busy_o) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_words_in_use(input logic [rswm_pkg::CFG_W-1:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    tracker.words_in_use = v;
  endtask

  // One random phase under one setting, ended by a full drain.
  task automatic random_phase(input logic [rswm_pkg::CFG_W-1:0] setting);
    int stop;
    int n;
    write_words_in_use(setting);
    stop = items_sent + PHASE_ITEMS;
    while (items_sent < stop) begin
      n = tracker.scan_span();
      case ($urandom_range(0, 9))
        0, 1, 2: program_word($urandom_range(0, rswm_pkg::MAX_WORDS_DEF - 1),
                              ($urandom_range(0, 7) == 0) ? $urandom_range(0, 31)
                                                          : $urandom_range(0, 6));
        3, 4, 5, 6: type_word((n > 0) ? $urandom_range(0, n - 1)
                                      : $urandom_range(0, rswm_pkg::MAX_WORDS_DEF - 1));
        7: noise_item();
        8: push_key(rswm_pkg::CHAR_W'($urandom_range(0, 255)));
        default: scan_words();
      endcase
    end
    wait_drained();
  endtask

  initial begin : stimulus
    logic [rswm_pkg::CFG_W-1:0] phase_words [7];
    tracker = new();
    phase_words = '{4'd15, 4'd0, rswm_pkg::CFG_W'($urandom_range(0, 15)), 4'd1, 4'd8,
                    rswm_pkg::CFG_W'($urandom_range(0, 15)), 4'd3};
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Out of reset no word is in use, so a scan gives the no-match result.
    idle_en = 1'b1;
    scan_words();
    wait_drained();
    write_words_in_use(4'd8);

    // All eight words are empty and fire.
    scan_words();
    // Suffix matches with extreme bytes and a zero byte inside a word.
    push_key(8'hff);
    push_key(8'h00);
    write_char(0, 0, 8'hff);
    write_char(0, 1, 8'h00);
    write_len(0, 2);
    write_char(1, 0, 8'h00);
    write_len(1, 1);
    write_char(rswm_pkg::MAX_WORDS_DEF - 1, rswm_pkg::MAX_WORD_LEN_DEF - 1, 8'haa);
    scan_words();
    // A word that differs in its older byte drops out.
    write_char(2, 0, 8'h00);
    write_char(2, 1, 8'h00);
    write_len(2, 2);
    scan_words();
    // An oversize length is stored as the maximum.
    write_len(rswm_pkg::MAX_WORDS_DEF - 1, 31);
    scan_words();
    wait_drained();

    // Random phases alternate between idling and back-to-back items.
    foreach (phase_words[i]) begin
      idle_en = (i % 2 == 0);
      random_phase(phase_words[i]);
    end

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (tracker.mismatches == 0 && tracker.expected_hits.size() == 0)
      $display("[ring_suffix_word_matcher_unit] OK");
    else
      $display("[ring_suffix_word_matcher_unit] ERROR");
    $finish;
  end

  // Hang guard, far beyond the slowest correct run.
  initial begin : watchdog
    #2000000;
    $display("[ring_suffix_word_matcher_unit] ERROR");
    $finish;
  end

endmodule

>>> filelist.f
hdl/rswm_pkg.sv
hdl/ring_suffix_word_matcher_unit.sv
bench/ring_suffix_word_matcher_unit_test.sv
